### sv/pspt_pkg.sv
// ----------------------------------------------------------------------------
// pspt_pkg
// Shared constants for the program association section table block.
// ----------------------------------------------------------------------------
package pspt_pkg;

   // clamp limits for the section length field
   localparam logic [9:0] MIN_LEN = 10'd9;
   localparam logic [9:0] MAX_LEN = 10'd1021;

   // slots per group in the free-slot search
   localparam int GRP = 16;

   // result kinds
   localparam logic KIND_SECTION = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LIST = 3'b010,
      ST_SLOT = 3'b100
   } state_type;

endpackage

### sv/pat_section_program_table_top.sv
// ----------------------------------------------------------------------------
// pat_section_program_table_top
// Program association section parser with per-table program lists.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one word per item: a section byte (kind 0) or a
//   read of a program entry at a list position (kind 1). rsp_ channel
//   returns one word when a section finishes or for every read.
//   Section bytes are parsed as they are taken, with no busy state between
//   them; the finished word is loaded into the output register when the last byte is taken.
//   A read steps through the list memory read, the slot memory read and
//   the load of the output register. No new word is taken while a read is in
//   progress.
//   Free slots are found by a two-stage registered priority search over the
//   slot occupancy flags; entries arrive four bytes apart, so the search is
//   always current when an entry is stored.
//   Reset clears the parser, all counts, headers and occupancy flags at
//   once; the slot and list memories need no clearing.
//   While the receiver stalls, the output word holds and the block stops
//   taking words until it is taken.
// ----------------------------------------------------------------------------
module pat_section_program_table_top
   import pspt_pkg::*;
#(
   parameter int TABLES = 4,
   parameter int SLOTS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [1:0]  req_table_select,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section_start,
   input  logic        req_clear_request,
   input  logic [7:0]  req_entry_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [10:0] rsp_total_length,
   output logic [15:0] rsp_stream_id,
   output logic [4:0]  rsp_version,
   output logic [7:0]  rsp_section_number,
   output logic [7:0]  rsp_last_section,
   output logic [7:0]  rsp_program_count,
   output logic [15:0] rsp_prog_num,
   output logic [12:0] rsp_program_pid,
   output logic        rsp_found
);

   localparam int TW       = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DEPTH    = TABLES * SLOTS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NG       = (SLOTS + GRP - 1) / GRP;
   localparam int NB       = NG * GRP;
   localparam int IW       = $clog2(NB);
   localparam int GIW      = $clog2(GRP);
   localparam int LIST_CAP = (SLOTS < 255) ? SLOTS : 255;

   // parser state
   logic [9:0]  pos_ff, len_ff;
   logic [3:0]  lenhi_ff;
   logic        active_ff, stop_ff;
   logic [23:0] pend_ff;

   // per-table state
   logic [15:0] stream_ff [TABLES];
   logic [4:0]  ver_ff    [TABLES];
   logic [7:0]  secn_ff   [TABLES];
   logic [7:0]  last_ff   [TABLES];
   logic [7:0]  count_ff  [TABLES];
   logic        ever_ff   [TABLES];
   logic [NB-1:0] occ_ff  [TABLES];

   // free-slot search pipeline
   logic          gfree_ff [TABLES][NG];
   logic [GIW-1:0] gidx_ff [TABLES][NG];
   logic          hasfree_ff [TABLES];
   logic [IW-1:0] freeidx_ff [TABLES];

   // read sequencer and output register
   state_type   state_ff;
   logic        hit_ff;
   logic [TW-1:0] rdt_ff;
   logic        rsp_valid_ff, rsp_kind_ff, rsp_found_ff;
   logic [10:0] rsp_len_ff;
   logic [15:0] rsp_stream_ff, rsp_number_ff;
   logic [4:0]  rsp_ver_ff;
   logic [7:0]  rsp_secn_ff, rsp_last_ff, rsp_count_ff;
   logic [12:0] rsp_pid_ff;

   // memory ports
   logic          slot_wr_en, list_wr_en, list_rd_en, slot_rd_en;
   logic [AW-1:0] slot_wr_addr, list_wr_addr, list_rd_addr, slot_rd_addr;
   logic [28:0]   slot_wr_data, slot_rd_data;
   logic [7:0]    list_wr_data, list_rd_data;

   // decode of the incoming word
   logic          accept, rsp_take, table_ok, is_byte, is_read;
   logic [TW-1:0] tix;
   logic [9:0]    p, off, nent;
   logic [11:0]   len_raw;
   logic          entry_byte, entry_last, finish, load_sec;
   logic [15:0]   number;
   logic [12:0]   pid;
   logic          store_try, store_ok, store_stop;
   logic [SW-1:0] free_slot;
   logic          hit_in;

   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign table_ok = (5'(req_table_select) < 5'(TABLES));
   assign tix = TW'(req_table_select);
   assign is_byte = accept && (req_kind == KIND_SECTION) && table_ok;
   assign is_read = accept && (req_kind == KIND_READ);

   // position and entry decode
   always_comb begin
      p = req_section_start ? 10'd0 : pos_ff;
      off = p - 10'd8;
      nent = (len_ff - MIN_LEN) >> 2;
      len_raw = {lenhi_ff, req_data_byte};
      entry_byte = (p >= 10'd8) && ((off >> 2) < nent);
      entry_last = entry_byte && (off[1:0] == 2'd3);
      finish = (p >= 10'd3) && (p == len_ff + 10'd2);
      load_sec = is_byte && (active_ff || req_section_start) && finish;
      number = pend_ff[23:8];
      pid = {pend_ff[4:0], req_data_byte};
      free_slot = SW'(freeidx_ff[tix]);
      store_try = is_byte && entry_last && (number != 16'd0) && !stop_ff;
      store_stop = store_try
         && ((count_ff[tix] >= 8'(LIST_CAP)) || !hasfree_ff[tix]);
      store_ok = store_try && !store_stop;
      hit_in = table_ok && (req_entry_position < count_ff[tix])
         && ({1'b0, req_entry_position} < 9'(SLOTS));
   end

   // memory addressing
   always_comb begin
      slot_wr_en   = store_ok;
      slot_wr_addr = AW'(tix) * AW'(SLOTS) + AW'(free_slot);
      slot_wr_data = {number, pid};
      list_wr_en   = store_ok;
      list_wr_addr = AW'(tix) * AW'(SLOTS) + AW'(count_ff[tix]);
      list_wr_data = 8'(free_slot);
      list_rd_en   = is_read;
      list_rd_addr = AW'(tix) * AW'(SLOTS) + AW'(req_entry_position);
      slot_rd_en   = (state_ff == ST_LIST);
      slot_rd_addr = AW'(rdt_ff) * AW'(SLOTS) + AW'(list_rd_data[SW-1:0]);
   end

   pspt_ram #(.WIDTH(29), .DEPTH(DEPTH)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   pspt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   // parse section bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         len_ff    <= '0;
         lenhi_ff  <= '0;
         active_ff <= 1'b0;
         stop_ff   <= 1'b0;
         pend_ff   <= '0;
         for (int t = 0; t < TABLES; t++) begin
            stream_ff[t] <= '0;
            ver_ff[t]    <= '0;
            secn_ff[t]   <= '0;
            last_ff[t]   <= '0;
            count_ff[t]  <= '0;
            ever_ff[t]   <= 1'b0;
            occ_ff[t]    <= '0;
         end
      end else if (is_byte) begin
         if (req_section_start) begin
            if (req_clear_request && ever_ff[tix]) begin
               occ_ff[tix] <= '0;
            end
            stop_ff       <= 1'b0;
            len_ff        <= '0;
            pend_ff       <= '0;
            count_ff[tix] <= '0;
         end
         if (active_ff || req_section_start) begin
            case (p)
               10'd0: ;
               10'd1: lenhi_ff <= req_data_byte[3:0];
               10'd2: begin
                  if (len_raw < 12'(MIN_LEN)) begin
                     len_ff <= MIN_LEN;
                  end else if (len_raw > 12'(MAX_LEN)) begin
                     len_ff <= MAX_LEN;
                  end else begin
                     len_ff <= len_raw[9:0];
                  end
               end
               10'd3: stream_ff[tix] <= {req_data_byte, 8'h00};
               10'd4: stream_ff[tix] <= stream_ff[tix] | {8'h00, req_data_byte};
               10'd5: ver_ff[tix] <= req_data_byte[5:1];
               10'd6: secn_ff[tix] <= req_data_byte;
               10'd7: last_ff[tix] <= req_data_byte;
               default: begin
                  if (entry_byte && !entry_last) begin
                     pend_ff <= {pend_ff[15:0], req_data_byte};
                  end
               end
            endcase
            if (store_stop) begin
               stop_ff <= 1'b1;
            end
            if (store_ok) begin
               occ_ff[tix][IW'(free_slot)] <= (pid != 13'd0);
               count_ff[tix] <= count_ff[tix] + 8'd1;
               ever_ff[tix]  <= 1'b1;
            end
            if (finish) begin
               active_ff <= 1'b0;
               pos_ff    <= '0;
            end else begin
               active_ff <= 1'b1;
               pos_ff    <= p + 10'd1;
            end
         end
      end
   end

   // search free slots: group stage, then table stage
   always_ff @(posedge clock) begin
      logic          any;
      logic [IW-1:0] idx;
      for (int t = 0; t < TABLES; t++) begin
         for (int g = 0; g < NG; g++) begin
            gfree_ff[t][g] <= 1'b0;
            gidx_ff[t][g]  <= '0;
            for (int j = GRP - 1; j >= 0; j--) begin
               if (!occ_ff[t][g*GRP+j] && (g * GRP + j < SLOTS)) begin
                  gfree_ff[t][g] <= 1'b1;
                  gidx_ff[t][g]  <= GIW'(j);
               end
            end
         end
         any = 1'b0;
         idx = '0;
         for (int g = NG - 1; g >= 0; g--) begin
            if (gfree_ff[t][g]) begin
               any = 1'b1;
               idx = IW'(g * GRP) | IW'(gidx_ff[t][g]);
            end
         end
         hasfree_ff[t] <= any;
         freeidx_ff[t] <= idx;
      end
   end

   // sequence reads and load the output word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (is_read) begin
                  state_ff <= ST_LIST;
               end
            end
            ST_LIST: state_ff <= ST_SLOT;
            ST_SLOT: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
         // raise on a new word, drop once the word is taken
         if (load_sec || (state_ff == ST_SLOT)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (is_read) begin
         hit_ff      <= hit_in;
         rdt_ff      <= tix;
         rsp_kind_ff <= KIND_READ;
         rsp_len_ff  <= '0;
         rsp_stream_ff <= table_ok ? stream_ff[tix] : 16'd0;
         rsp_ver_ff    <= table_ok ? ver_ff[tix] : 5'd0;
         rsp_secn_ff   <= table_ok ? secn_ff[tix] : 8'd0;
         rsp_last_ff   <= table_ok ? last_ff[tix] : 8'd0;
         rsp_count_ff  <= table_ok ? count_ff[tix] : 8'd0;
      end else if (load_sec) begin
         rsp_kind_ff   <= KIND_SECTION;
         rsp_len_ff    <= 11'(len_ff) + 11'd3;
         rsp_stream_ff <= stream_ff[tix];
         rsp_ver_ff    <= ver_ff[tix];
         rsp_secn_ff   <= secn_ff[tix];
         rsp_last_ff   <= last_ff[tix];
         rsp_count_ff  <= count_ff[tix];
         rsp_number_ff <= '0;
         rsp_pid_ff    <= '0;
         rsp_found_ff  <= 1'b0;
      end
      if (state_ff == ST_SLOT) begin
         rsp_number_ff <= hit_ff ? slot_rd_data[28:13] : 16'd0;
         rsp_pid_ff    <= hit_ff ? slot_rd_data[12:0] : 13'd0;
         rsp_found_ff  <= hit_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_total_length   = rsp_len_ff;
   assign rsp_stream_id      = rsp_stream_ff;
   assign rsp_version        = rsp_ver_ff;
   assign rsp_section_number = rsp_secn_ff;
   assign rsp_last_section   = rsp_last_ff;
   assign rsp_program_count  = rsp_count_ff;
   assign rsp_prog_num       = rsp_number_ff;
   assign rsp_program_pid    = rsp_pid_ff;
   assign rsp_found          = rsp_found_ff;

endmodule

### sv/pspt_ram.sv
// ----------------------------------------------------------------------------
// pspt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pspt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
